// ===== hw/rtl/scps_pkg.sv =====
`default_nettype none
package scps_pkg;

   localparam int COORD_W  = 32;
   localparam int CUT_W    = 31;
   localparam int CHG_W    = 32;
   localparam int IDX_W    = 6;
   localparam int POT_W    = 64;
   localparam int CNT_W    = 7;
   localparam int REQ_W    = 168;
   localparam int MAG_W    = 33;
   localparam int NSQ_W    = 68;
   localparam int ROOT_W   = 35;
   localparam int NUM_W    = 70;
   localparam int DEN_W    = 35;
   localparam int MUL_W    = 38;
   localparam int PRD_W    = 2 * MUL_W;
   localparam int POW_W    = 33;
   localparam int POLY_W   = 41;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef struct packed {
      logic [CHG_W-1:0]   charge;
      logic [CUT_W-1:0]   cutoff;
      logic [COORD_W-1:0] pos_z;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_x;
   } atom_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/scps_atom_ram.sv =====
`default_nettype none
module scps_atom_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire scps_pkg::atom_type   wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output scps_pkg::atom_type        rd_data
);

   scps_pkg::atom_type mem [DEPTH];
   scps_pkg::atom_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/scps_isqrt.sv =====
`default_nettype none
module scps_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [scps_pkg::NSQ_W-1:0]    radicand,
   output logic                               done,
   output logic [scps_pkg::ROOT_W-1:0]        root
);

   localparam int PAD_W = 2 * scps_pkg::ROOT_W;
   localparam int REM_W = scps_pkg::ROOT_W + 3;

   logic [PAD_W-1:0]           n_ff;
   logic [REM_W-1:0]           rem_ff;
   logic [scps_pkg::ROOT_W-1:0] root_ff;
   logic [5:0]                 cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [REM_W-1:0]           rem_sh;
   logic [REM_W-1:0]           trial;
   logic                       fits;

   assign rem_sh = {rem_ff[REM_W-3:0], n_ff[PAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(scps_pkg::ROOT_W);
            n_ff    <= PAD_W'(radicand);
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            n_ff    <= {n_ff[PAD_W-3:0], 2'b00};
            rem_ff  <= fits ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[scps_pkg::ROOT_W-2:0], fits};
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/scps_div.sv =====
`default_nettype none
module scps_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [scps_pkg::NUM_W-1:0]  dividend,
   input  wire logic [scps_pkg::DEN_W-1:0]  divisor,
   output logic                             done,
   output logic [scps_pkg::NUM_W-1:0]       quotient
);

   localparam int NW = scps_pkg::NUM_W;
   localparam int DW = scps_pkg::DEN_W;

   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff;
   logic [6:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW:0]   rem_sh;
   logic          fits;

   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'(NW);
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
            num_ff <= {num_ff[NW-2:0], fits};
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/smeared_charge_potential_sum_unit.sv =====
// Smeared-charge potential sum unit.
// req channel: tuser = op (0 loads an atom slot, 1 evaluates a point), tlast = batch_end,
// tdata = atom_index, pos_x, pos_y, pos_z, cutoff_radius, charge (low bits first).
// A load beat is written into the atom memory in the cycle it is accepted, no response.
// An evaluate beat yields one rsp beat: tdata = saturated Q32.32 potential, tlast =
// batch_end. csr_wr_en/csr_wr_data set atom_count; write it only while idle.
// Atoms are processed one at a time from the memory through one multiplier, a 2-bit-per-
// cycle square root unit and a 1-bit-per-cycle divider.
// Per atom: the squared distance, the square root and one divide (charge over distance)
// outside the cutoff radius; inside it that divide gives s, followed by the powers of s,
// the polynomial, the product with the charge and the final divide. One item at a time;
// req_tready is high only while no item is in flight.
// The result sits in an output register; the next item is accepted while it waits,
// and the engine stalls only if a new result is ready before rsp_tready takes the old one.
// Reset clears atom_count, the sequencer and rsp_tvalid; memory contents are kept and
// are undefined until loaded.
`default_nettype none
module smeared_charge_potential_sum_unit #(
   parameter int MAX_ATOMS = 64,
   parameter int DIM       = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // atom_index[5:0], pos_x[37:6], pos_y[69:38], pos_z[101:70], cutoff_radius[132:102],
   // charge[164:133], zero fill
   input  wire logic [scps_pkg::REQ_W-1:0]    req_tdata,
   // op
   input  wire logic                          req_tuser,
   input  wire logic                          req_tlast,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // potential[63:0]
   output logic [scps_pkg::POT_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast,
   input  wire logic                          csr_wr_en,
   input  wire logic [scps_pkg::CNT_W-1:0]    csr_wr_data
);

   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int XW = (AW > scps_pkg::IDX_W) ? AW : scps_pkg::IDX_W;
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int CRW = (CW > scps_pkg::CNT_W) ? CW : scps_pkg::CNT_W;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_FETCH, S_SQ, S_SQA, S_ROOT, S_CMP, S_DIVQ,
      S_PW, S_PWA, S_POLY, S_PMUL, S_PMULA, S_TDIV, S_TERM, S_ACC, S_DONE
   } state_type;

   state_type state_ff;

   logic [scps_pkg::CNT_W-1:0]   count_ff;
   logic [CW-1:0]                n_ff;
   logic [CW-1:0]                k_ff;
   logic [scps_pkg::COORD_W-1:0] pt_ff [3];
   logic                         last_ff;
   logic [scps_pkg::MAG_W-1:0]   dmag_ff [3];
   logic [1:0]                   j_ff;
   logic [scps_pkg::NSQ_W-1:0]   nsum_ff;
   logic [scps_pkg::ROOT_W-1:0]  r_ff;
   logic [scps_pkg::CUT_W-1:0]   rc_ff;
   logic [scps_pkg::CHG_W-1:0]   zm_ff;
   logic                         zneg_ff;
   logic                         pneg_ff;
   logic                         coul_ff;
   logic [scps_pkg::POW_W-1:0]   s_ff, s2_ff, s4_ff, s5_ff, s6_ff, s7_ff;
   logic [2:0]                   pw_ff;
   logic [scps_pkg::MUL_W-1:0]   pabs_ff;
   logic [scps_pkg::NUM_W-1:0]   tmag_ff;
   logic                         tneg_ff;
   logic [scps_pkg::POT_W-1:0]   term_ff;
   logic [scps_pkg::POT_W-1:0]   acc_ff;
   logic [scps_pkg::POT_W-1:0]   rsp_data_ff;
   logic                         rsp_last_ff;
   logic                         rsp_valid_ff;
   logic [scps_pkg::PRD_W-1:0]   prod_ff;

   scps_pkg::unit_ctl_type       sq_ctl;
   scps_pkg::unit_ctl_type       dv_ctl;
   logic                         sq_start_ff;
   logic                         dv_start_ff;
   logic [scps_pkg::NUM_W-1:0]   dv_num_ff;
   logic [scps_pkg::DEN_W-1:0]   dv_den_ff;
   logic [scps_pkg::ROOT_W-1:0]  sq_root;
   logic [scps_pkg::NUM_W-1:0]   dv_quo;

   scps_pkg::atom_type           wr_atom;
   scps_pkg::atom_type           rd_atom;
   logic                         in_fire;
   logic                         wr_en;
   logic [XW-1:0]                idx_ext;
   logic [CW-1:0]                n_eff;
   logic [scps_pkg::COORD_W-1:0] in_pos [3];
   logic [scps_pkg::COORD_W-1:0] at_pos [3];
   logic [scps_pkg::MAG_W-1:0]   dmag [3];
   logic [scps_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [scps_pkg::POLY_W-1:0] poly;
   logic [scps_pkg::POLY_W-1:0]  poly_abs;
   logic [scps_pkg::POT_W:0]     sum65;

   assign in_fire = req_tvalid && req_tready;
   assign idx_ext = XW'(req_tdata[5:0]);
   assign wr_en   = in_fire && (req_tuser == scps_pkg::OP_LOAD)
                    && (32'(req_tdata[5:0]) < MAX_ATOMS);
   assign n_eff   = (32'(count_ff) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(CRW'(count_ff));

   assign in_pos[0] = req_tdata[37:6];
   assign in_pos[1] = req_tdata[69:38];
   assign in_pos[2] = req_tdata[101:70];

   always_comb begin
      wr_atom.pos_x  = req_tdata[37:6];
      wr_atom.pos_y  = req_tdata[69:38];
      wr_atom.pos_z  = req_tdata[101:70];
      wr_atom.cutoff = req_tdata[132:102];
      wr_atom.charge = req_tdata[164:133];
   end

   scps_atom_ram #(.DEPTH(MAX_ATOMS), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_data (wr_atom),
      .rd_en   (state_ff == S_READ),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (rd_atom)
   );

   assign sq_ctl.start = sq_start_ff;
   assign dv_ctl.start = dv_start_ff;

   scps_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_ctl.start),
      .radicand (nsum_ff),
      .done     (sq_ctl.done),
      .root     (sq_root)
   );

   scps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_ctl.start),
      .dividend (dv_num_ff),
      .divisor  (dv_den_ff),
      .done     (dv_ctl.done),
      .quotient (dv_quo)
   );

   assign at_pos[0] = rd_atom.pos_x;
   assign at_pos[1] = rd_atom.pos_y;
   assign at_pos[2] = rd_atom.pos_z;

   always_comb begin
      logic [scps_pkg::MAG_W-1:0] d;
      for (int j = 0; j < 3; j++) begin
         d = {pt_ff[j][31], pt_ff[j]} - {at_pos[j][31], at_pos[j]};
         dmag[j] = d[scps_pkg::MAG_W-1] ? -d : d;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQ) begin
         mul_a = scps_pkg::MUL_W'(dmag_ff[j_ff]);
         mul_b = scps_pkg::MUL_W'(dmag_ff[j_ff]);
      end else if (state_ff == S_PW) begin
         case (pw_ff)
            3'd0: begin mul_a = scps_pkg::MUL_W'(s_ff);  mul_b = scps_pkg::MUL_W'(s_ff);  end
            3'd1: begin mul_a = scps_pkg::MUL_W'(s2_ff); mul_b = scps_pkg::MUL_W'(s2_ff); end
            3'd2: begin mul_a = scps_pkg::MUL_W'(s4_ff); mul_b = scps_pkg::MUL_W'(s_ff);  end
            3'd3: begin mul_a = scps_pkg::MUL_W'(s5_ff); mul_b = scps_pkg::MUL_W'(s_ff);  end
            3'd4: begin mul_a = scps_pkg::MUL_W'(s6_ff); mul_b = scps_pkg::MUL_W'(s_ff);  end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == S_PMUL) begin
         mul_a = scps_pkg::MUL_W'(zm_ff);
         mul_b = pabs_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign poly = $signed(scps_pkg::POLY_W'(s7_ff)) * 9
               - $signed(scps_pkg::POLY_W'(s6_ff)) * 30
               + $signed(scps_pkg::POLY_W'(s5_ff)) * 28
               - $signed(scps_pkg::POLY_W'(s2_ff)) * 14
               + $signed(scps_pkg::POLY_W'(64'd12) << 32);
   assign poly_abs = poly[scps_pkg::POLY_W-1] ? -poly : poly;
   assign sum65 = {acc_ff[63], acc_ff} + {term_ff[63], term_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
         dv_start_ff  <= 1'b0;
      end else begin
         sq_start_ff <= 1'b0;
         dv_start_ff <= 1'b0;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (in_fire && (req_tuser == scps_pkg::OP_EVAL)) begin
                  for (int j = 0; j < 3; j++) begin
                     pt_ff[j] <= in_pos[j];
                  end
                  last_ff  <= req_tlast;
                  n_ff     <= n_eff;
                  k_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= (n_eff == '0) ? S_DONE : S_READ;
               end
            end
            S_READ: state_ff <= S_FETCH;
            S_FETCH: begin
               for (int j = 0; j < 3; j++) begin
                  dmag_ff[j] <= dmag[j];
               end
               rc_ff    <= (rd_atom.cutoff == '0) ? scps_pkg::CUT_W'(1) : rd_atom.cutoff;
               zneg_ff  <= rd_atom.charge[scps_pkg::CHG_W-1];
               zm_ff    <= rd_atom.charge[scps_pkg::CHG_W-1] ? -rd_atom.charge
                                                              : rd_atom.charge;
               nsum_ff  <= '0;
               j_ff     <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               j_ff     <= j_ff + 2'd1;
               state_ff <= S_SQA;
            end
            S_SQA: begin
               nsum_ff <= nsum_ff + scps_pkg::NSQ_W'(prod_ff[65:0]);
               if (j_ff == 2'(DIM)) begin
                  sq_start_ff <= 1'b1;
                  state_ff    <= S_ROOT;
               end else begin
                  state_ff <= S_SQ;
               end
            end
            S_ROOT: begin
               if (sq_ctl.done) begin
                  r_ff     <= sq_root;
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               dv_start_ff <= 1'b1;
               state_ff    <= S_DIVQ;
               if (r_ff > scps_pkg::ROOT_W'(rc_ff)) begin
                  coul_ff   <= 1'b1;
                  dv_num_ff <= scps_pkg::NUM_W'({zm_ff, 32'd0});
                  dv_den_ff <= r_ff;
               end else begin
                  coul_ff   <= 1'b0;
                  dv_num_ff <= scps_pkg::NUM_W'({r_ff, 32'd0});
                  dv_den_ff <= scps_pkg::DEN_W'(rc_ff);
               end
            end
            S_DIVQ: begin
               if (dv_ctl.done) begin
                  if (coul_ff) begin
                     tmag_ff  <= dv_quo;
                     tneg_ff  <= zneg_ff;
                     state_ff <= S_TERM;
                  end else begin
                     s_ff     <= dv_quo[scps_pkg::POW_W-1:0];
                     pw_ff    <= '0;
                     state_ff <= S_PW;
                  end
               end
            end
            S_PW: state_ff <= S_PWA;
            S_PWA: begin
               case (pw_ff)
                  3'd0: s2_ff <= prod_ff[64:32];
                  3'd1: s4_ff <= prod_ff[64:32];
                  3'd2: s5_ff <= prod_ff[64:32];
                  3'd3: s6_ff <= prod_ff[64:32];
                  default: s7_ff <= prod_ff[64:32];
               endcase
               if (pw_ff == 3'd4) begin
                  state_ff <= S_POLY;
               end else begin
                  pw_ff    <= pw_ff + 3'd1;
                  state_ff <= S_PW;
               end
            end
            S_POLY: begin
               pneg_ff  <= poly[scps_pkg::POLY_W-1];
               pabs_ff  <= poly_abs[scps_pkg::MUL_W-1:0];
               state_ff <= S_PMUL;
            end
            S_PMUL: state_ff <= S_PMULA;
            S_PMULA: begin
               dv_num_ff   <= prod_ff[scps_pkg::NUM_W-1:0];
               dv_den_ff   <= scps_pkg::DEN_W'({rc_ff, 2'b00}) + scps_pkg::DEN_W'(rc_ff);
               dv_start_ff <= 1'b1;
               state_ff    <= S_TDIV;
            end
            S_TDIV: begin
               if (dv_ctl.done) begin
                  tmag_ff  <= dv_quo;
                  tneg_ff  <= zneg_ff ^ pneg_ff;
                  state_ff <= S_TERM;
               end
            end
            S_TERM: begin
               if (tneg_ff) begin
                  term_ff <= (|tmag_ff[scps_pkg::NUM_W-1:63]) ? {1'b1, 63'd0}
                                                               : -{1'b0, tmag_ff[62:0]};
               end else begin
                  term_ff <= (|tmag_ff[scps_pkg::NUM_W-1:63]) ? {1'b0, {63{1'b1}}}
                                                               : {1'b0, tmag_ff[62:0]};
               end
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (sum65[64] != sum65[63]) begin
                  acc_ff <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
               end else begin
                  acc_ff <= sum65[63:0];
               end
               k_ff     <= k_ff + CW'(1);
               state_ff <= (k_ff + CW'(1) == n_ff) ? S_DONE : S_READ;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= acc_ff;
                  rsp_last_ff  <= last_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== verif/smeared_charge_potential_sum_unit_tb.sv =====
`timescale 1ns / 1ps
module smeared_charge_potential_sum_unit_tb;

   localparam int NATOMS = 64;
   localparam int WDOG_LIMIT = 200000;

   typedef struct {
      logic           op;
      logic [5:0]     idx;
      logic [31:0]    x, y, z;
      logic [30:0]    cut;
      logic [31:0]    chg;
      logic           last;
   } atom_req_type;

   typedef struct {
      logic [63:0] pot;
      logic        last;
   } pot_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [scps_pkg::REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [scps_pkg::POT_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_wr_en = 1'b0;
   logic [scps_pkg::CNT_W-1:0] csr_wr_data = '0;

   atom_req_type pending[$];
   pot_rsp_type  expected_pots[$];
   atom_req_type cur;
   logic [31:0] tbl_x[NATOMS], tbl_y[NATOMS], tbl_z[NATOMS], tbl_chg[NATOMS];
   logic [30:0] tbl_cut[NATOMS];
   logic [6:0]  atoms_summed = '0;
   int sender_idle_pct = 0;
   int rcvr_stall_pct = 0;
   int n_errors = 0;
   int wdog = 0;

   smeared_charge_potential_sum_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      if (a == 64'h1_0000_0000) return b;
      if (b == 64'h1_0000_0000) return a;
      prod = 128'(a) * 128'(b);
      return prod[95:32];
   endfunction

   function automatic longint clamp_signed(logic [63:0] mag, logic neg);
      if (neg) begin
         if (mag[63]) return 64'sh8000_0000_0000_0000;
         return -$signed(mag);
      end
      if (mag[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return $signed(mag);
   endfunction

   function automatic longint atom_potential(int k, logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz);
      longint pt[3], at[3], d, z, p;
      logic [67:0] dm, nsq;
      logic [69:0] sq;
      logic [34:0] root, c;
      logic [63:0] rc, zm, s, s2, s4, s5, s6, s7, pm, q;
      logic [127:0] quo;
      pt[0] = longint'($signed(px));
      pt[1] = longint'($signed(py));
      pt[2] = longint'($signed(pz));
      at[0] = longint'($signed(tbl_x[k]));
      at[1] = longint'($signed(tbl_y[k]));
      at[2] = longint'($signed(tbl_z[k]));
      nsq = '0;
      for (int j = 0; j < 3; j++) begin
         d = pt[j] - at[j];
         dm = 68'(d < 0 ? -d : d);
         nsq = nsq + dm * dm;
      end
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         c = root | (35'd1 << b);
         sq = 70'(c) * 70'(c);
         if (sq <= 70'(nsq)) root = c;
      end
      rc = (tbl_cut[k] == 0) ? 64'd1 : 64'(tbl_cut[k]);
      z = longint'($signed(tbl_chg[k]));
      zm = z < 0 ? -z : z;
      if (64'(root) > rc) begin
         q = (zm << 32) / 64'(root);
         return clamp_signed(q, z < 0);
      end
      s = (64'(root) << 32) / rc;
      s2 = q32_mul(s, s);
      s4 = q32_mul(s2, s2);
      s5 = q32_mul(s4, s);
      s6 = q32_mul(s5, s);
      s7 = q32_mul(s6, s);
      p = 9 * $signed(s7) - 30 * $signed(s6) + 28 * $signed(s5) - 14 * $signed(s2)
          + 12 * 64'sh1_0000_0000;
      pm = p < 0 ? -p : p;
      quo = (128'(zm) * 128'(pm)) / 128'(5 * rc);
      q = (quo[127:64] != 0) ? '1 : quo[63:0];
      return clamp_signed(q, (z < 0) != (p < 0));
   endfunction

   task automatic apply_beat(atom_req_type it);
      longint acc, t;
      int n;
      pot_rsp_type r;
      if (it.op == scps_pkg::OP_LOAD) begin
         tbl_x[it.idx] = it.x;
         tbl_y[it.idx] = it.y;
         tbl_z[it.idx] = it.z;
         tbl_cut[it.idx] = it.cut;
         tbl_chg[it.idx] = it.chg;
      end else begin
         n = atoms_summed > NATOMS ? NATOMS : atoms_summed;
         acc = 0;
         for (int k = 0; k < n; k++) begin
            t = atom_potential(k, it.x, it.y, it.z);
            if (t > 0 && acc > 64'sh7FFF_FFFF_FFFF_FFFF - t) acc = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (t < 0 && acc < 64'sh8000_0000_0000_0000 - t)
               acc = 64'sh8000_0000_0000_0000;
            else acc = acc + t;
         end
         r.pot = acc;
         r.last = it.last;
         expected_pots.push_back(r);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) apply_beat(cur);
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               cur = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur.op;
               req_tlast <= cur.last;
               req_tdata <= {3'b0, cur.chg, cur.cut, cur.z, cur.y, cur.x, cur.idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      n_errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      pot_rsp_type e;
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= rcvr_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pots.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, '0);
            end else begin
               e = expected_pots.pop_front();
               if (rsp_tdata !== e.pot) report_mismatch("potential", rsp_tdata, e.pot);
               if (rsp_tlast !== e.last)
                  report_mismatch("tlast", 64'(rsp_tlast), 64'(e.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) wdog <= 0;
      else if (wdog >= WDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else wdog <= wdog + 1;
   end

   task automatic push_load(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [30:0] cut, logic [31:0] chg);
      atom_req_type it;
      it.op = scps_pkg::OP_LOAD;
      it.idx = 6'(idx);
      it.x = x;
      it.y = y;
      it.z = z;
      it.cut = cut;
      it.chg = chg;
      it.last = 1'($urandom_range(1));
      pending.push_back(it);
   endtask

   task automatic push_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      atom_req_type it;
      it.op = scps_pkg::OP_EVAL;
      it.idx = 6'($urandom);
      it.x = x;
      it.y = y;
      it.z = z;
      it.cut = 31'($urandom);
      it.chg = $urandom;
      it.last = last;
      pending.push_back(it);
   endtask

   // sampled at the falling edge, after the driver's updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending.size() != 0 || req_tvalid || expected_pots.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_atoms_summed(logic [6:0] n);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      atoms_summed = n;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_coord();
      if ($urandom_range(3) == 0) return $urandom;
      return 32'($urandom_range(8 << 16)) - 32'(4 << 16);
   endfunction

   function automatic logic [30:0] rnd_cutoff();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return '0;
      if (sel == 1) return 31'($urandom);
      return 31'($urandom_range(3 << 16, 1));
   endfunction

   function automatic logic [31:0] rnd_charge();
      if ($urandom_range(1)) return $urandom;
      return 32'($urandom_range(16 << 16)) - 32'(8 << 16);
   endfunction

   localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] PMIN = 32'h8000_0000;
   localparam logic [31:0] ONE  = 32'h0001_0000;

   initial begin
      int cnt, eff, n_items;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NATOMS; k++)
         push_load(k, $urandom, $urandom, $urandom, 31'($urandom), $urandom);

      // directed
      push_eval(0, 0, 0, 1'b1);
      set_atoms_summed(7'd4);
      for (int k = 0; k < 4; k++) push_load(k, 0, 0, 0, 31'd0, PMAX);
      push_eval(0, 0, 0, 1'b0);
      for (int k = 0; k < 4; k++) push_load(k, 0, 0, 0, 31'd0, PMIN);
      push_eval(0, 0, 0, 1'b1);
      push_load(0, PMAX, PMAX, PMAX, 31'h7FFF_FFFF, ONE);
      push_load(1, 0, 0, 0, 31'h0001_0000, PMIN);
      push_load(2, PMIN, PMIN, PMIN, 31'd1, 32'd1);
      push_load(3, 32'h0003_0000, 0, 0, 31'h0000_8000, -ONE);
      push_eval(ONE, 0, 0, 1'b0);
      push_eval(PMIN, PMIN, PMIN, 1'b1);
      push_eval(PMAX, PMAX, PMAX, 1'b0);
      push_load(63, 0, 0, 0, 31'h0002_0000, ONE);
      push_eval(0, 0, 0, 1'b1);
      set_atoms_summed(7'd127);
      push_eval(ONE, ONE, ONE, 1'b0);
      set_atoms_summed(7'd64);
      push_eval(0, 0, 0, 1'b1);

      // random
      for (int ph = 0; ph < 12; ph++) begin
         cnt = (ph == 5) ? 64 : (ph == 9) ? 127 : (ph == 2) ? 0 : $urandom_range(4, 1);
         eff = cnt > NATOMS ? NATOMS : cnt;
         n_items = eff >= 32 ? 8 : 200;
         set_atoms_summed(7'(cnt));
         case (ph % 4)
            0: begin sender_idle_pct = 0;  rcvr_stall_pct = 0;  end
            1: begin sender_idle_pct = 67; rcvr_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rcvr_stall_pct = 67; end
            default: begin sender_idle_pct = 37; rcvr_stall_pct = 37; end
         endcase
         for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) wait_drained();
            if ($urandom_range(9) < 4)
               push_load($urandom_range(NATOMS - 1), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_cutoff(), rnd_charge());
            else
               push_eval(rnd_coord(), rnd_coord(), rnd_coord(), 1'($urandom_range(1)));
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (n_errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== smeared_charge_potential_sum_unit.f =====
hw/rtl/scps_pkg.sv
hw/rtl/scps_atom_ram.sv
hw/rtl/scps_isqrt.sv
hw/rtl/scps_div.sv
hw/rtl/smeared_charge_potential_sum_unit.sv
verif/smeared_charge_potential_sum_unit_tb.sv
